@@ design/hmn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmn_pkg
// Shared types and constants of the height to normal map stream.
// ----------------------------------------------------------------------------
package hmn_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int PIX_W    = 8;
   localparam int DIM_W    = 11;
   localparam int SCALE_W  = 16;
   localparam int COORD_W  = 10;
   localparam int NORM_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [DIM_W-1:0]   MIN_DIM       = 11'd4;
   localparam logic [DIM_W-1:0]   DIM_RESET     = 11'd1024;
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd256;
   localparam logic [15:0]        Q14_ONE       = 16'd16384;
   localparam logic [24:0]        Z_GAIN        = 25'd510;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Z      = 3'd4;

   typedef struct packed {
      logic [SCALE_W-1:0] sx;
      logic [SCALE_W-1:0] sy;
      logic [SCALE_W-1:0] sz;
   } scale_type;

endpackage

@@ design/hmn_job_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmn_job_queue
// Two-entry queue that carries classified pixel jobs from front to back.
// ----------------------------------------------------------------------------
module hmn_job_queue import hmn_pkg::*; #(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              pop_valid
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wp_ff;
   logic              rp_ff;
   logic [1:0]        cnt_ff;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("job popped from an empty queue");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue fill level did not follow a push");

endmodule

@@ design/hmn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmn_front
// Accepts height pixels, keeps the height line buffers and forms one job per
// pixel with its neighborhood, its source column and the rows it emits.
// ----------------------------------------------------------------------------
module hmn_front import hmn_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CW = $clog2(MAX_WIDTH),
   parameter int RW = $clog2(MAX_HEIGHT),
   parameter int JOB_W = 38 + 3 * CW + 2 * RW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] width_eff,
   input  logic [DIM_W-1:0] height_eff,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_height_sample,
   output logic             job_push,
   output logic [JOB_W-1:0] job_data,
   input  logic             job_ready
);

   typedef struct packed {
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] c;
      logic [PIX_W-1:0] d;
      logic             mk;
      logic             bank;
      logic [CW-1:0]    u;
      logic [CW-1:0]    cm;
      logic [CW-1:0]    col;
      logic [3:0]       mask;
      logic [RW-1:0]    srow;
      logic [RW-1:0]    hlast;
   } job_type;

   typedef enum logic { F_IDLE, F_LOAD } fstate_type;

   fstate_type       state_ff;
   logic [CW-1:0]    col_ff;
   logic [RW-1:0]    row_ff;
   logic             nwork_ff;
   logic [1:0]       ci_ff;
   logic [1:0]       cur_ff;
   logic [CW-1:0]    xcol_ff;
   logic [RW-1:0]    yrow_ff;
   logic             bank_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] left_ff;
   logic [PIX_W-1:0] pv1_ff;
   logic [PIX_W-1:0] pv2_ff;
   logic [PIX_W-1:0] q1_ff;

   logic [PIX_W-1:0] lbuf [3][MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff [3];

   logic             accept;
   logic             end_row;
   logic [1:0]       pi;
   logic [1:0]       p2;
   logic [PIX_W-1:0] prev_rd;
   logic [PIX_W-1:0] prev2_rd;
   job_type          job;

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;
   assign end_row   = (32'(col_ff) + 1 >= 32'(width_eff));
   assign job_push  = (state_ff == F_LOAD) && job_ready;
   assign job_data  = job;

   always_comb begin
      pi       = (cur_ff == 2'd0) ? 2'd2 : cur_ff - 2'd1;
      p2       = (cur_ff == 2'd2) ? 2'd0 : cur_ff + 2'd1;
      prev_rd  = rd_ff[pi];
      prev2_rd = rd_ff[p2];

      job.a    = prev_rd;
      job.b    = pv2_ff;
      job.c    = left_ff;
      job.d    = q1_ff;
      job.mk   = (32'(yrow_ff) >= 2) && (32'(xcol_ff) >= 2);
      job.bank = bank_ff;
      job.u    = xcol_ff - CW'(1);
      job.col  = xcol_ff;
      if (32'(xcol_ff) <= 1) begin
         job.cm = CW'(2);
      end else if (32'(xcol_ff) == 32'(width_eff) - 1) begin
         job.cm = CW'(32'(width_eff) - 2);
      end else begin
         job.cm = xcol_ff;
      end
      if (32'(yrow_ff) >= 3) begin
         job.mask[0] = (32'(yrow_ff) == 3);
         job.mask[1] = (32'(yrow_ff) < 32'(height_eff));
         job.mask[2] = (32'(yrow_ff) + 1 == 32'(height_eff));
         job.mask[3] = (32'(yrow_ff) + 1 == 32'(height_eff));
      end else begin
         job.mask = 4'd0;
      end
      job.srow  = yrow_ff - RW'(2);
      job.hlast = RW'(32'(height_eff) - 1);
   end

   // Only the two lines above the current one are read.
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (accept) begin
            if (ci_ff == 2'(k)) begin
               lbuf[k][col_ff] <= req_height_sample;
            end else begin
               rd_ff[k] <= lbuf[k][col_ff];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_height_sample;
         xcol_ff <= col_ff;
         yrow_ff <= row_ff;
         cur_ff  <= ci_ff;
         bank_ff <= nwork_ff;
      end
      if (job_push) begin
         pv1_ff <= prev_rd;
         pv2_ff <= pv1_ff;
         q1_ff  <= prev2_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         nwork_ff <= 1'b0;
         ci_ff    <= 2'd0;
         left_ff  <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_LOAD;
                  if (end_row) begin
                     col_ff   <= '0;
                     ci_ff    <= (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
                     nwork_ff <= ~nwork_ff;
                     if (32'(row_ff) + 1 >= 32'(height_eff)) begin
                        row_ff <= '0;
                     end else begin
                        row_ff <= row_ff + RW'(1);
                     end
                  end else begin
                     col_ff <= col_ff + CW'(1);
                  end
               end
            end
            F_LOAD: begin
               if (job_ready) begin
                  left_ff  <= pix_ff;
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

@@ design/hmn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmn_back
// Computes and normalizes the central-difference normal of each job that
// forms one, keeps the two normal lines and sends out the replicated results.
// ----------------------------------------------------------------------------
module hmn_back import hmn_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CW = $clog2(MAX_WIDTH),
   parameter int RW = $clog2(MAX_HEIGHT),
   parameter int JOB_W = 38 + 3 * CW + 2 * RW
) (
   input  logic               clock,
   input  logic               reset,
   input  scale_type          scale,
   input  logic               job_valid,
   input  logic [JOB_W-1:0]   job_data,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_out_column,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic [NORM_W-1:0]  rsp_normal_x,
   output logic [NORM_W-1:0]  rsp_normal_y,
   output logic [NORM_W-1:0]  rsp_normal_z,
   output logic               rsp_run_last
);

   typedef struct packed {
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] c;
      logic [PIX_W-1:0] d;
      logic             mk;
      logic             bank;
      logic [CW-1:0]    u;
      logic [CW-1:0]    cm;
      logic [CW-1:0]    col;
      logic [3:0]       mask;
      logic [RW-1:0]    srow;
      logic [RW-1:0]    hlast;
   } job_type;

   typedef enum logic [3:0] {
      B_IDLE, B_MAG, B_SQ, B_ROOT, B_DINIT, B_DIV, B_WR, B_RD, B_EMIT
   } bstate_type;

   bstate_type        state_ff;
   job_type           job_ff;
   logic [24:0]       mx_ff;
   logic [24:0]       my_ff;
   logic [24:0]       mz_ff;
   logic              sgx_ff;
   logic              sgy_ff;
   logic [1:0]        cnt_ff;
   logic [49:0]       prod_ff;
   logic [51:0]       acc_ff;
   logic [63:0]       rad_ff;
   logic [35:0]       rem_ff;
   logic [31:0]       root_ff;
   logic [4:0]        step_ff;
   logic [1:0]        comp_ff;
   logic [3:0]        dstep_ff;
   logic [31:0]       drem_ff;
   logic [15:0]       dlow_ff;
   logic [15:0]       q_ff;
   logic [NORM_W-1:0] n_ff [3];
   logic [3:0]        mask_ff;
   logic [47:0]       nrd_ff;
   logic [47:0]       nmem [2][MAX_WIDTH];

   job_type           job_new;
   logic              emit;
   logic [PIX_W-1:0]  dab;
   logic [PIX_W-1:0]  dcd;
   logic [24:0]       sq_op;
   logic [35:0]       rem_sh;
   logic [35:0]       trial;
   logic [24:0]       mag_sel;
   logic [45:0]       numr;
   logic [32:0]       r2;
   logic              qbit;
   logic [15:0]       q_next;
   logic [15:0]       q_sat;
   logic              neg_sel;
   logic [NORM_W-1:0] n_val;
   logic [3:0]        mask_left;
   logic [RW-1:0]     row_val;

   assign job_pop = (state_ff == B_IDLE) && job_valid;

   always_comb begin
      job_new = job_type'(job_data);
      emit    = (state_ff == B_EMIT) && (mask_ff != 4'd0) && (!rsp_valid || rsp_ready);
      dab     = (job_ff.b >= job_ff.a) ? job_ff.b - job_ff.a : job_ff.a - job_ff.b;
      dcd     = (job_ff.c >= job_ff.d) ? job_ff.c - job_ff.d : job_ff.d - job_ff.c;
      sq_op   = (cnt_ff == 2'd0) ? mx_ff : ((cnt_ff == 2'd1) ? my_ff : mz_ff);
      rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      mag_sel = (comp_ff == 2'd0) ? mx_ff : ((comp_ff == 2'd1) ? my_ff : mz_ff);
      neg_sel = (comp_ff == 2'd0) ? sgx_ff : ((comp_ff == 2'd1) ? sgy_ff : 1'b0);
      numr    = {1'b0, mag_sel, 20'd0} + 46'(root_ff >> 1);
      r2      = {drem_ff, dlow_ff[15]};
      qbit    = (r2 >= {1'b0, root_ff});
      q_next  = {q_ff[14:0], qbit};
      q_sat   = (q_next > Q14_ONE) ? Q14_ONE : q_next;
      n_val   = neg_sel ? NORM_W'(-q_sat) : NORM_W'(q_sat);

      mask_left = mask_ff;
      row_val   = job_ff.hlast;
      if (mask_ff[0]) begin
         row_val      = '0;
         mask_left[0] = 1'b0;
      end else if (mask_ff[1]) begin
         row_val      = job_ff.srow;
         mask_left[1] = 1'b0;
      end else if (mask_ff[2]) begin
         row_val      = job_ff.hlast - RW'(1);
         mask_left[2] = 1'b0;
      end else begin
         mask_left[3] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_WR) begin
         nmem[job_ff.bank][job_ff.u] <= {n_ff[0], n_ff[1], n_ff[2]};
      end
      if (state_ff == B_RD) begin
         nrd_ff <= nmem[~job_ff.bank][job_ff.cm];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rsp_valid <= 1'b0;
         mask_ff   <= 4'd0;
      end else begin
         if (emit) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_new;
                  state_ff <= job_new.mk ? B_MAG : B_RD;
               end
            end
            B_MAG: begin
               mx_ff    <= 25'(dab) * 25'(scale.sx);
               my_ff    <= 25'(dcd) * 25'(scale.sy);
               mz_ff    <= 25'(scale.sz) * Z_GAIN;
               sgx_ff   <= (job_ff.b < job_ff.a);
               sgy_ff   <= (job_ff.c < job_ff.d);
               cnt_ff   <= 2'd0;
               state_ff <= B_SQ;
            end
            B_SQ: begin
               prod_ff <= {25'd0, sq_op} * {25'd0, sq_op};
               cnt_ff  <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd0) begin
                  acc_ff <= '0;
               end else begin
                  acc_ff <= acc_ff + 52'(prod_ff);
               end
               if (cnt_ff == 2'd3) begin
                  rad_ff   <= {acc_ff + 52'(prod_ff), 12'd0};
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= B_ROOT;
               end
            end
            B_ROOT: begin
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               rad_ff  <= {rad_ff[61:0], 2'b00};
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd31) begin
                  comp_ff  <= 2'd0;
                  state_ff <= B_DINIT;
               end
            end
            B_DINIT: begin
               drem_ff  <= {2'b00, numr[45:16]};
               dlow_ff  <= numr[15:0];
               q_ff     <= '0;
               dstep_ff <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               drem_ff  <= qbit ? 32'(r2 - {1'b0, root_ff}) : r2[31:0];
               dlow_ff  <= {dlow_ff[14:0], 1'b0};
               q_ff     <= q_next;
               dstep_ff <= dstep_ff + 4'd1;
               if (dstep_ff == 4'd15) begin
                  n_ff[comp_ff] <= n_val;
                  if (comp_ff == 2'd2) begin
                     state_ff <= B_WR;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= B_DINIT;
                  end
               end
            end
            B_WR: begin
               state_ff <= B_RD;
            end
            B_RD: begin
               mask_ff  <= job_ff.mask;
               state_ff <= B_EMIT;
            end
            B_EMIT: begin
               if (mask_ff == 4'd0) begin
                  state_ff <= B_IDLE;
               end else if (emit) begin
                  rsp_out_column <= COORD_W'(job_ff.col);
                  rsp_out_row    <= COORD_W'(row_val);
                  rsp_normal_x   <= nrd_ff[47:32];
                  rsp_normal_y   <= nrd_ff[31:16];
                  rsp_normal_z   <= nrd_ff[15:0];
                  rsp_run_last   <= (mask_left == 4'd0);
                  mask_ff        <= mask_left;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

@@ design/height_to_normal_map_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_to_normal_map_stream
// Streaming height map to normal map converter with edge replication.
// ----------------------------------------------------------------------------
// Height pixels enter in raster order and leave as Q1.14 normals with their
// coordinates; each pixel from row three on releases up to four results, the
// last flagged by run_last. A pixel that forms an interior normal passes through
// the shared squaring multiplier, the 32-step square root and three 16-step
// divisions done one after another before its results go out one at a time;
// a pixel of the first two rows or columns skips them. A two-entry job
// queue lets the front keep accepting pixels while the back works.
// ----------------------------------------------------------------------------
module height_to_normal_map_stream import hmn_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_height_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COORD_W-1:0]   rsp_out_column,
   output logic [COORD_W-1:0]   rsp_out_row,
   output logic [NORM_W-1:0]    rsp_normal_x,
   output logic [NORM_W-1:0]    rsp_normal_y,
   output logic [NORM_W-1:0]    rsp_normal_z,
   output logic                 rsp_run_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int JOB_W = 38 + 3 * CW + 2 * RW;

   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;
   logic [SCALE_W-1:0] scale_x_ff;
   logic [SCALE_W-1:0] scale_y_ff;
   logic [SCALE_W-1:0] scale_z_ff;
   logic [DIM_W-1:0]   width_eff;
   logic [DIM_W-1:0]   height_eff;
   scale_type          scale;

   logic               job_push;
   logic               job_ready;
   logic [JOB_W-1:0]   job_in;
   logic               job_pop;
   logic               job_valid;
   logic [JOB_W-1:0]   job_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
         scale_x_ff      <= SCALE_RESET;
         scale_y_ff      <= SCALE_RESET;
         scale_z_ff      <= SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data[DIM_W-1:0];
            REG_SCALE_X:      scale_x_ff      <= csr_data;
            REG_SCALE_Y:      scale_y_ff      <= csr_data;
            REG_SCALE_Z:      scale_z_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (image_width_ff < MIN_DIM) begin
         width_eff = MIN_DIM;
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff < MIN_DIM) begin
         height_eff = MIN_DIM;
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = image_height_ff;
      end
      if (scale_x_ff == '0 || scale_y_ff == '0 || scale_z_ff == '0) begin
         scale.sx = SCALE_W'(width_eff);
         scale.sy = SCALE_W'(height_eff);
         scale.sz = (width_eff < height_eff) ? SCALE_W'(width_eff) : SCALE_W'(height_eff);
      end else begin
         scale.sx = scale_x_ff;
         scale.sy = scale_y_ff;
         scale.sz = scale_z_ff;
      end
   end

   hmn_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW),
      .JOB_W      (JOB_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .width_eff         (width_eff),
      .height_eff        (height_eff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_height_sample (req_height_sample),
      .job_push          (job_push),
      .job_data          (job_in),
      .job_ready         (job_ready)
   );

   hmn_job_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .push_ready (job_ready),
      .pop        (job_pop),
      .pop_data   (job_out),
      .pop_valid  (job_valid)
   );

   hmn_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW),
      .JOB_W      (JOB_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .scale          (scale),
      .job_valid      (job_valid),
      .job_data       (job_out),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

@@ tb/sv/height_to_normal_map_stream_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_to_normal_map_stream_tb
// Self-checking testbench of the streaming height map to normal map converter.
// ----------------------------------------------------------------------------
// Whole images of random or patterned heights are streamed through the block
// under several sizes and scale settings, including clamped sizes and zero
// scales. A built-in line-buffer predictor computes every expected normal,
// and each result transfer is compared field by field. Both channels idle at
// random, and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module height_to_normal_map_stream_tb;
   import hmn_pkg::*;

   typedef struct {
      bit [COORD_W-1:0] column;
      bit [COORD_W-1:0] row;
      bit [NORM_W-1:0]  nx;
      bit [NORM_W-1:0]  ny;
      bit [NORM_W-1:0]  nz;
      bit               last;
   } normal_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_height_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COORD_W-1:0]   rsp_out_column;
   logic [COORD_W-1:0]   rsp_out_row;
   logic [NORM_W-1:0]    rsp_normal_x;
   logic [NORM_W-1:0]    rsp_normal_y;
   logic [NORM_W-1:0]    rsp_normal_z;
   logic                 rsp_run_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   height_to_normal_map_stream DUT (.*);

   normal_result_type pending_normals[$];
   int                mismatch_count = 0;
   longint            cycle_count = 0;
   bit                quiet_mode = 0;
   int                hold_request = 0;

   bit [DIM_W-1:0]   cfg_width = DIM_RESET;
   bit [DIM_W-1:0]   cfg_height = DIM_RESET;
   bit [SCALE_W-1:0] cfg_scale[3] = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};

   bit [7:0] line_prev[1024];
   bit [7:0] line_prev2[1024];
   bit [7:0] line_cur[1024];
   bit [7:0] left_pix = 0;
   int       col_pos = 0;
   int       row_pos = 0;
   int       work_sel = 0;
   int       normal_line[2][1024][3];

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int clamp_dim(bit [DIM_W-1:0] v);
      if (v < 4) return 4;
      if (v > 1024) return 1024;
      return int'(v);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int to_q14(longint v, longint unsigned len);
      longint unsigned mag = (v < 0) ? -v : v;
      longint unsigned q = ((mag << 20) + len / 2) / len;
      if (q > 16384) q = 16384;
      return (v < 0) ? -int'(q) : int'(q);
   endfunction

   // Normal of one interior pixel from its four neighbors.
   task automatic form_normal(input int a, input int b, input int c, input int d,
                              output int n[3]);
      int      w = clamp_dim(cfg_width);
      int      h = clamp_dim(cfg_height);
      longint  es[3];
      longint  vx, vy, vz;
      longint unsigned len;
      if (cfg_scale[0] == 0 || cfg_scale[1] == 0 || cfg_scale[2] == 0) begin
         es[0] = w;
         es[1] = h;
         es[2] = (w < h) ? w : h;
      end else begin
         es[0] = cfg_scale[0];
         es[1] = cfg_scale[1];
         es[2] = cfg_scale[2];
      end
      vx = (b - a) * es[0];
      vy = (c - d) * es[1];
      vz = 510 * es[2];
      len = root64((vx * vx + vy * vy + vz * vz) << 12);
      n[0] = to_q14(vx, len);
      n[1] = to_q14(vy, len);
      n[2] = to_q14(vz, len);
   endtask

   task automatic predict_pixel(input bit [7:0] p);
      int w = clamp_dim(cfg_width);
      int h = clamp_dim(cfg_height);
      int x = col_pos;
      int y = row_pos;
      int s, cm;
      int n[3];
      int rows[$];
      normal_result_type r;
      line_cur[x] = p;
      if (y >= 2 && x >= 2) begin
         form_normal(int'(line_prev[x]), int'(line_prev[x-2]), int'(left_pix),
                     int'(line_prev2[x-1]), n);
         normal_line[work_sel][x-1] = n;
      end
      if (y >= 3) begin
         s = y - 2;
         cm = (x <= 1) ? 2 : ((x == w - 1) ? w - 2 : x);
         if (s == 1) rows.push_back(0);
         if (s >= 1 && s + 2 < h) rows.push_back(s);
         if (s + 3 == h) begin
            rows.push_back(h - 2);
            rows.push_back(h - 1);
         end
         foreach (rows[i]) begin
            r.column = COORD_W'(x);
            r.row = COORD_W'(rows[i]);
            r.nx = NORM_W'(normal_line[work_sel ^ 1][cm][0]);
            r.ny = NORM_W'(normal_line[work_sel ^ 1][cm][1]);
            r.nz = NORM_W'(normal_line[work_sel ^ 1][cm][2]);
            r.last = (i == rows.size() - 1);
            pending_normals.push_back(r);
         end
      end
      left_pix = p;
      if (x + 1 >= w) begin
         col_pos = 0;
         line_prev2 = line_prev;
         line_prev = line_cur;
         work_sel ^= 1;
         row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endtask

   function automatic int pick_gap();
      int roll = $urandom_range(99);
      if (quiet_mode || roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Receiver: random short and long hold-offs, plus one requested long stall.
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (hold_request > 0) begin
         rsp_gap = hold_request;
         hold_request = 0;
      end
      if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      normal_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_normals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result transfer at (%0d, %0d).",
                        rsp_out_column, rsp_out_row);
         end else begin
            e = pending_normals.pop_front();
            if (rsp_out_column !== e.column || rsp_out_row !== e.row ||
                rsp_normal_x !== e.nx || rsp_normal_y !== e.ny ||
                rsp_normal_z !== e.nz || rsp_run_last !== e.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Mismatch: expected (%0d,%0d) %h %h %h last %0d, ",
                            "got (%0d,%0d) %h %h %h last %0d."},
                           e.column, e.row, e.nx, e.ny, e.nz, e.last,
                           rsp_out_column, rsp_out_row, rsp_normal_x, rsp_normal_y,
                           rsp_normal_z, rsp_run_last);
            end
         end
      end
   end

   task automatic send_pixel(input bit [7:0] p);
      int gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_height_sample <= p;
      do @(posedge clock); while (!req_ready);
      predict_pixel(p);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width = DIM_W'(value);
         REG_IMAGE_HEIGHT: cfg_height = DIM_W'(value);
         REG_SCALE_X:      cfg_scale[0] = SCALE_W'(value);
         REG_SCALE_Y:      cfg_scale[1] = SCALE_W'(value);
         REG_SCALE_Z:      cfg_scale[2] = SCALE_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_image(input int w, input int h, input int sx, input int sy,
                            input int sz);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_SCALE_X, sx);
      write_reg(REG_SCALE_Y, sy);
      write_reg(REG_SCALE_Z, sz);
   endtask

   task automatic send_random_image();
      int n = clamp_dim(cfg_width) * clamp_dim(cfg_height);
      int roll;
      repeat (n) begin
         roll = $urandom_range(9);
         if (roll == 0) send_pixel(8'h00);
         else if (roll == 1) send_pixel(8'hFF);
         else send_pixel(8'($urandom_range(255)));
      end
   endtask

   task automatic test_clamped_extremes();
      bit [7:0] pattern[16] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00,
                                8'h01, 8'h80, 8'h7F, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h00};
      set_image(2, 3, 65535, 1, 65535);
      foreach (pattern[i]) send_pixel(pattern[i]);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 0);
      write_reg(REG_IMAGE_HEIGHT, 0);
      foreach (pattern[i]) send_pixel(~pattern[i]);
      wait_idle();
   endtask

   task automatic test_scale_settings();
      set_image(5, 6, 0, 256, 256);
      send_random_image();
      wait_idle();
      set_image(7, 5, 1, 65535, 1);
      send_random_image();
      wait_idle();
      set_image(6, 4, 300, 700, 0);
      send_random_image();
      wait_idle();
   endtask

   task automatic test_random_images();
      int img = 0;
      while (img < 3) begin
         set_image($urandom_range(5, 4), $urandom_range(5, 4),
                   ($urandom_range(4) == 0) ? 0 : $urandom_range(65535),
                   $urandom_range(65535, 1), $urandom_range(65535, 1));
         quiet_mode = (img % 3 == 2);
         if (img == 1) hold_request = 600;
         send_random_image();
         if (img == 2) begin
            req_valid <= 1'b0;
            while (pending_normals.size() != 0) @(posedge clock);
         end
         img++;
         wait_idle();
      end
      quiet_mode = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clamped_extremes();
      test_scale_settings();
      test_random_images();
      wait_idle();
      if (mismatch_count == 0 && pending_normals.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
